// ----- rtl/core/cpsat_pkg.sv -----
package cpsat_pkg;

  localparam int MAX_VERTS_DEF = 16;

  localparam int COORD_W = 16;
  localparam int WORLD_W = COORD_W + 1;
  localparam int NORM_W  = COORD_W + 1;
  localparam int PROD_W  = WORLD_W + NORM_W;
  localparam int DOT_W   = PROD_W + 1;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_TEST   = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EDGE0,
    ST_EDGE1,
    ST_EDGE2,
    ST_PROJ_A,
    ST_PROJ_B,
    ST_DRAIN,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic vld;
    logic sel_b;
    logic first;
  } proj_tag_t;

  typedef struct packed {
    logic signed [DOT_W-1:0] a_lo;
    logic signed [DOT_W-1:0] a_hi;
    logic signed [DOT_W-1:0] b_lo;
    logic signed [DOT_W-1:0] b_hi;
  } span_t;

endpackage

// ----- rtl/core/cpsat_proj.sv -----
module cpsat_proj
  import cpsat_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  proj_tag_t                 tag_i,
  input  logic signed [COORD_W-1:0] vx_i,
  input  logic signed [COORD_W-1:0] vy_i,
  input  logic signed [COORD_W-1:0] a_ox_i,
  input  logic signed [COORD_W-1:0] a_oy_i,
  input  logic signed [COORD_W-1:0] b_ox_i,
  input  logic signed [COORD_W-1:0] b_oy_i,
  input  logic signed [NORM_W-1:0]  nx_i,
  input  logic signed [NORM_W-1:0]  ny_i,
  output span_t                     span_o,
  output logic                      busy_o
);

  proj_tag_t tag1_r, tag2_r;
  logic signed [WORLD_W-1:0] wx_r, wy_r;
  logic signed [PROD_W-1:0]  px_r, py_r;
  logic signed [COORD_W-1:0] ox, oy;
  logic signed [DOT_W-1:0]   dot;
  span_t                     span_r;

  assign ox = tag_i.sel_b ? b_ox_i : a_ox_i;
  assign oy = tag_i.sel_b ? b_oy_i : a_oy_i;

  assign dot = $signed({px_r[PROD_W-1], px_r}) + $signed({py_r[PROD_W-1], py_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
    end
  end

  // world coordinates, then products, then interval update
  always_ff @(posedge clk) begin
    wx_r <= $signed({vx_i[COORD_W-1], vx_i}) + $signed({ox[COORD_W-1], ox});
    wy_r <= $signed({vy_i[COORD_W-1], vy_i}) + $signed({oy[COORD_W-1], oy});
    px_r <= PROD_W'(wx_r) * PROD_W'(nx_i);
    py_r <= PROD_W'(wy_r) * PROD_W'(ny_i);
    if (tag2_r.vld) begin
      if (tag2_r.sel_b) begin
        if (tag2_r.first || dot < span_r.b_lo) span_r.b_lo <= dot;
        if (tag2_r.first || dot > span_r.b_hi) span_r.b_hi <= dot;
      end else begin
        if (tag2_r.first || dot < span_r.a_lo) span_r.a_lo <= dot;
        if (tag2_r.first || dot > span_r.a_hi) span_r.a_hi <= dot;
      end
    end
  end

  assign span_o = span_r;
  assign busy_o = tag_i.vld | tag1_r.vld | tag2_r.vld;

endmodule

// ----- rtl/core/convex_polygon_sat_collision.sv -----
// load beats are cmd 0/1; a test projects on the axis of each edge of A then B in turn,
//   stopping at the first separating axis, or skips the axis loop on an empty polygon
// the axis loop reads one vertex per cycle from the per-polygon vertex memories
// a result waits in the output register while vertex loads are still accepted
// synchronous active-low reset clears counts, overflow flag and handshake state;
//   vertex memories are not cleared
module convex_polygon_sat_collision
  import cpsat_pkg::*;
#(
  parameter int MAX_VERTS = MAX_VERTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vert_x, vert_y, pos_a_x, pos_a_y, pos_b_x, pos_b_y
  input  logic [95:0]  in_tdata,
  // cmd
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // colliding, error, zero fill
  output logic [7:0]   out_tdata
);

  localparam int CNT_W = $clog2(MAX_VERTS + 1);
  localparam int IDX_W = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTS);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic [2*COORD_W-1:0] mem_a [MAX_VERTS];
  logic [2*COORD_W-1:0] mem_b [MAX_VERTS];
  logic [2*COORD_W-1:0] rd_a_r, rd_b_r;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_a_r, count_b_r;
  logic             ovf_r;
  logic             edge_b_r;
  logic [IDX_W-1:0] edge_idx_r, proj_idx_r;
  proj_tag_t        tag0_r;
  logic             err_r, hit_r;
  logic             out_valid_r, out_coll_r, out_err_r;

  logic signed [COORD_W-1:0] pos_a_x_r, pos_a_y_r, pos_b_x_r, pos_b_y_r;
  logic signed [COORD_W-1:0] prev_x_r, prev_y_r;
  logic signed [NORM_W-1:0]  nx_r, ny_r;

  logic [1:0]          cmd;
  logic [COORD_W-1:0]  vert_x, vert_y;
  logic                in_fire, is_test, empty;
  logic [CNT_W-1:0]    edge_cnt, edge_cnt_m1, edge_nxt_cnt, proj_nxt_cnt;
  logic [IDX_W-1:0]    prev_idx;
  logic                edge_last, last_a, last_b, sep, out_free;
  logic [2*COORD_W-1:0] edge_rd;
  logic signed [COORD_W-1:0] cur_x, cur_y;

  logic [IDX_W-1:0] addr_a, addr_b;
  proj_tag_t        iss_tag;
  logic             we_a, we_b, ovf_set, test_go, cap_prev, cap_norm, done_fire;

  span_t span;
  logic  proj_busy;

  assign cmd    = in_tuser;
  assign vert_x = in_tdata[15:0];
  assign vert_y = in_tdata[31:16];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign is_test   = (cmd == CMD_TEST);
  assign empty     = (count_a_r == '0) | (count_b_r == '0);

  assign edge_cnt     = edge_b_r ? count_b_r : count_a_r;
  assign edge_cnt_m1  = edge_cnt - ONE_CNT;
  assign prev_idx     = (edge_idx_r == '0) ? edge_cnt_m1[IDX_W-1:0] : edge_idx_r - IDX_W'(1);
  assign edge_nxt_cnt = CNT_W'(edge_idx_r) + ONE_CNT;
  assign edge_last    = (edge_nxt_cnt == edge_cnt);
  assign proj_nxt_cnt = CNT_W'(proj_idx_r) + ONE_CNT;
  assign last_a       = (proj_nxt_cnt == count_a_r);
  assign last_b       = (proj_nxt_cnt == count_b_r);
  assign out_free     = ~out_valid_r | out_tready;

  assign edge_rd = edge_b_r ? rd_b_r : rd_a_r;
  assign cur_x   = edge_rd[COORD_W-1:0];
  assign cur_y   = edge_rd[2*COORD_W-1:COORD_W];

  assign sep = (span.a_lo > span.b_hi) || (span.a_hi < span.b_lo);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && is_test) state_nxt = empty ? ST_DONE : ST_EDGE0;
      end
      ST_EDGE0:  state_nxt = ST_EDGE1;
      ST_EDGE1:  state_nxt = ST_EDGE2;
      ST_EDGE2:  state_nxt = ST_PROJ_A;
      ST_PROJ_A: if (last_a) state_nxt = ST_PROJ_B;
      ST_PROJ_B: if (last_b) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!proj_busy) state_nxt = ST_CHECK;
      ST_CHECK: begin
        priority if (sep) state_nxt = ST_DONE;
        else if (edge_last && edge_b_r) state_nxt = ST_DONE;
        else state_nxt = ST_EDGE0;
      end
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    addr_a    = proj_idx_r;
    addr_b    = proj_idx_r;
    iss_tag   = '0;
    we_a      = 1'b0;
    we_b      = 1'b0;
    ovf_set   = 1'b0;
    test_go   = 1'b0;
    cap_prev  = 1'b0;
    cap_norm  = 1'b0;
    done_fire = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd)
            CMD_LOAD_A: begin
              if (count_a_r >= MAX_CNT) ovf_set = 1'b1;
              else we_a = 1'b1;
            end
            CMD_LOAD_B: begin
              if (count_b_r >= MAX_CNT) ovf_set = 1'b1;
              else we_b = 1'b1;
            end
            CMD_TEST: test_go = 1'b1;
            default: ;
          endcase
        end
      end
      ST_EDGE0: begin
        addr_a = prev_idx;
        addr_b = prev_idx;
      end
      ST_EDGE1: begin
        addr_a   = edge_idx_r;
        addr_b   = edge_idx_r;
        cap_prev = 1'b1;
      end
      ST_EDGE2: cap_norm = 1'b1;
      ST_PROJ_A: begin
        iss_tag.vld   = 1'b1;
        iss_tag.sel_b = 1'b0;
        iss_tag.first = (proj_idx_r == '0);
      end
      ST_PROJ_B: begin
        iss_tag.vld   = 1'b1;
        iss_tag.sel_b = 1'b1;
        iss_tag.first = (proj_idx_r == '0);
      end
      ST_DRAIN: ;
      ST_CHECK: ;
      ST_DONE:  done_fire = out_free;
      default: ;
    endcase
  end

  // vertex stores and registered vertex reads
  always_ff @(posedge clk) begin
    if (we_a) mem_a[count_a_r[IDX_W-1:0]] <= {vert_y, vert_x};
    if (we_b) mem_b[count_b_r[IDX_W-1:0]] <= {vert_y, vert_x};
    rd_a_r <= mem_a[addr_a];
    rd_b_r <= mem_b[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_a_r   <= '0;
      count_b_r   <= '0;
      ovf_r       <= 1'b0;
      edge_b_r    <= 1'b0;
      edge_idx_r  <= '0;
      proj_idx_r  <= '0;
      tag0_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tag0_r  <= iss_tag;
      if (we_a) count_a_r <= count_a_r + ONE_CNT;
      if (we_b) count_b_r <= count_b_r + ONE_CNT;
      if (ovf_set) ovf_r <= 1'b1;
      if (test_go) begin
        edge_b_r   <= 1'b0;
        edge_idx_r <= '0;
        proj_idx_r <= '0;
      end
      if (state_r == ST_PROJ_A) proj_idx_r <= last_a ? '0 : proj_nxt_cnt[IDX_W-1:0];
      if (state_r == ST_PROJ_B) proj_idx_r <= last_b ? '0 : proj_nxt_cnt[IDX_W-1:0];
      if (state_r == ST_CHECK && !sep) begin
        if (edge_last) begin
          edge_idx_r <= '0;
          edge_b_r   <= 1'b1;
        end else begin
          edge_idx_r <= edge_nxt_cnt[IDX_W-1:0];
        end
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
        count_a_r   <= '0;
        count_b_r   <= '0;
        ovf_r       <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (test_go) begin
      pos_a_x_r <= in_tdata[47:32];
      pos_a_y_r <= in_tdata[63:48];
      pos_b_x_r <= in_tdata[79:64];
      pos_b_y_r <= in_tdata[95:80];
      err_r     <= ovf_r | empty;
      hit_r     <= 1'b0;
    end
    if (state_r == ST_CHECK && !sep && edge_last && edge_b_r) hit_r <= 1'b1;
    if (cap_prev) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
    // perpendicular of the edge from the previous vertex to this one
    if (cap_norm) begin
      nx_r <= $signed({cur_y[COORD_W-1], cur_y}) - $signed({prev_y_r[COORD_W-1], prev_y_r});
      ny_r <= $signed({prev_x_r[COORD_W-1], prev_x_r}) - $signed({cur_x[COORD_W-1], cur_x});
    end
    if (done_fire) begin
      out_coll_r <= hit_r;
      out_err_r  <= err_r;
    end
  end

  cpsat_proj u_proj (
    .clk    (clk),
    .rst_n  (rst_n),
    .tag_i  (tag0_r),
    .vx_i   (tag0_r.sel_b ? rd_b_r[COORD_W-1:0] : rd_a_r[COORD_W-1:0]),
    .vy_i   (tag0_r.sel_b ? rd_b_r[2*COORD_W-1:COORD_W] : rd_a_r[2*COORD_W-1:COORD_W]),
    .a_ox_i (pos_a_x_r),
    .a_oy_i (pos_a_y_r),
    .b_ox_i (pos_b_x_r),
    .b_oy_i (pos_b_y_r),
    .nx_i   (nx_r),
    .ny_i   (ny_r),
    .span_o (span),
    .busy_o (proj_busy)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_err_r, out_coll_r};

  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !proj_busy)
    else $error("projection pipeline busy while accepting beats");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done state");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_a_r <= MAX_CNT) && (count_b_r <= MAX_CNT))
    else $error("vertex count beyond capacity");

  a_proj_a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROJ_A) |-> (CNT_W'(proj_idx_r) < count_a_r))
    else $error("read of unfilled entry of polygon a");

  a_proj_b_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROJ_B) |-> (CNT_W'(proj_idx_r) < count_b_r))
    else $error("read of unfilled entry of polygon b");

endmodule
